[rtl/salloc_pkg.sv]
// shared types and constants for the slot allocator with free stack
package salloc_pkg;

   // field widths
   localparam int unsigned CMD_W      = 1;
   localparam int unsigned OFFSET_W   = 12;
   localparam int unsigned RECORDS_W  = 11;
   localparam int unsigned BUMP_W     = 13;
   localparam int unsigned CSR_DATA_W = 13;
   localparam int unsigned CSR_IDX_W  = 1;

   // bytes taken by one free stack record
   localparam int unsigned RECORD_BYTES = 4;

   // configuration register values after reset
   localparam int unsigned RST_SLOT_COUNT = 256;
   localparam int unsigned RST_SLOT_BYTES = 16;

   // request commands
   localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_BYTES = 1'b1;

   // request transaction
   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [OFFSET_W-1:0] slot_offset;
   } req_payload_type;

   // response transaction
   typedef struct packed {
      logic                 ok;
      logic [OFFSET_W-1:0]  granted_offset;
      logic [RECORDS_W-1:0] free_records;
      logic [BUMP_W-1:0]    bump_top;
   } rsp_payload_type;

   // compare flags of the shared adder
   typedef struct packed {
      logic gt;
      logic eq;
   } alu_flags_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_CHECK,
      ST_STACK,
      ST_POP
   } state_type;

endpackage

[rtl/salloc_alu.sv]
// shared add and compare unit: sum = a + b, compared against c
module salloc_alu #(
   parameter int unsigned W = 15
) (
   input  logic [W-1:0]                  op_a,
   input  logic [W-1:0]                  op_b,
   input  logic [W-1:0]                  op_c,
   output logic [W-1:0]                  sum,
   output salloc_pkg::alu_flags_type     flags
);

   // one adder, one magnitude compare
   always_comb begin
      sum      = op_a + op_b;
      flags.gt = (sum > op_c);
      flags.eq = (sum == op_c);
   end

endmodule

[rtl/salloc_stack_mem.sv]
// free stack record memory, one write port and one registered read port
module salloc_stack_mem #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned IW    = 10
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [IW-1:0]                     wr_addr,
   input  logic [salloc_pkg::OFFSET_W-1:0]   wr_data,
   input  logic                              rd_en,
   input  logic [IW-1:0]                     rd_addr,
   output logic [salloc_pkg::OFFSET_W-1:0]   rd_data
);

   logic [salloc_pkg::OFFSET_W-1:0] mem [DEPTH];
   logic [salloc_pkg::OFFSET_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/slot_allocator_with_free_stack_top.sv]
// slot allocator top level: sequencer, pointers, csr and response register
//
// Hands out fixed-size slots from a region of min(slot_count * slot_bytes,
// REGION_BYTES) bytes: new slots come from a bump pointer at the bottom, and
// freed offsets are kept as 4-byte records on a stack that grows down from the
// top of the region. A request transaction is taken in the idle state and its
// response is registered from the check step for frees above the top slot
// or of the top slot, else from the stack or pop step after it; the next
// request is taken only once the sequencer is back in idle, so transactions
// do not overlap. The steps are set by the single shared adder/comparator,
// used in two steps (slot bound, then stack bound), and by the registered
// read of the free stack memory on a pop. A response waiting on rsp_ready
// holds the sequencer in its last step. A write on the csr port
// re-initializes both pointers in the following cycle, during which no
// request is taken.
module slot_allocator_with_free_stack_top #(
   parameter int unsigned REGION_BYTES = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  salloc_pkg::req_payload_type           req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output salloc_pkg::rsp_payload_type           rsp_payload,
   input  logic                                  csr_we,
   input  logic [salloc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [salloc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // derived sizes
   localparam int unsigned DEPTH = REGION_BYTES / salloc_pkg::RECORD_BYTES;
   localparam int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW    = $clog2(DEPTH + 1);
   localparam int unsigned RW    = $clog2(REGION_BYTES + 1);
   localparam int unsigned AW    = ((RW > salloc_pkg::BUMP_W + 1) ? RW :
                                    salloc_pkg::BUMP_W + 1) + 1;
   localparam int unsigned PW    = 2 * salloc_pkg::CSR_DATA_W;
   localparam int unsigned RST_PROD = salloc_pkg::RST_SLOT_COUNT *
                                      salloc_pkg::RST_SLOT_BYTES;
   localparam int unsigned RST_REGION = (RST_PROD > REGION_BYTES) ? REGION_BYTES :
                                        RST_PROD;

   // state
   salloc_pkg::state_type              state_ff, state_in;
   salloc_pkg::req_payload_type        item_ff;
   logic [salloc_pkg::CSR_DATA_W-1:0]  slot_count_ff, slot_bytes_ff, size_ff;
   logic [RW-1:0]                      bump_ff, sb_ff;
   logic [CW-1:0]                      count_ff;
   logic [AW-1:0]                      tmp_ff;
   logic                               rsp_valid_ff;
   salloc_pkg::rsp_payload_type        rsp_payload_ff;

   // sequencer outputs
   logic [AW-1:0]                      alu_a, alu_b, alu_c, alu_sum;
   salloc_pkg::alu_flags_type          alu_flags;
   logic                               out_free, commit, res_ok;
   logic [salloc_pkg::OFFSET_W-1:0]    res_granted, rd_data;
   logic                               bump_upd, push, pop, tmp_load, rd_en;
   logic [RW-1:0]                      bump_new;
   logic                               is_alloc, stack_empty, req_accept;

   // region size from the configuration registers
   logic [PW-1:0]                      prod;
   logic [RW-1:0]                      region_in;

   assign is_alloc    = (item_ff.cmd == salloc_pkg::CMD_ALLOC);
   assign stack_empty = (count_ff == '0);
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready   = (state_ff == salloc_pkg::ST_IDLE);
   assign req_accept  = req_valid && req_ready;

   // shared adder and compare
   salloc_alu #(.W(AW)) u_alu (
      .op_a  (alu_a),
      .op_b  (alu_b),
      .op_c  (alu_c),
      .sum   (alu_sum),
      .flags (alu_flags)
   );

   // free stack records
   salloc_stack_mem #(.DEPTH(DEPTH), .IW(IW)) u_stack_mem (
      .clock   (clock),
      .wr_en   (commit && push),
      .wr_addr (IW'(count_ff)),
      .wr_data (item_ff.slot_offset),
      .rd_en   (rd_en),
      .rd_addr (IW'(count_ff - 1'b1)),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         salloc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = salloc_pkg::ST_CHECK;
            end
         end
         salloc_pkg::ST_INIT: begin
            state_in = salloc_pkg::ST_IDLE;
         end
         salloc_pkg::ST_CHECK: begin
            if (is_alloc) begin
               state_in = stack_empty ? salloc_pkg::ST_STACK : salloc_pkg::ST_POP;
            end else if (alu_flags.gt || alu_flags.eq) begin
               if (out_free) begin
                  state_in = salloc_pkg::ST_IDLE;
               end
            end else begin
               state_in = salloc_pkg::ST_STACK;
            end
         end
         salloc_pkg::ST_STACK, salloc_pkg::ST_POP: begin
            if (out_free) begin
               state_in = salloc_pkg::ST_IDLE;
            end
         end
         default: state_in = salloc_pkg::ST_IDLE;
      endcase
      // a register write re-initializes the pointers
      if (csr_we) begin
         state_in = salloc_pkg::ST_INIT;
      end
   end

   // sequencer outputs: operand select and step results
   always_comb begin
      alu_a       = AW'(bump_ff);
      alu_b       = AW'(size_ff);
      alu_c       = AW'(bump_ff);
      commit      = 1'b0;
      res_ok      = 1'b0;
      res_granted = '0;
      bump_upd    = 1'b0;
      bump_new    = bump_ff;
      push        = 1'b0;
      pop         = 1'b0;
      tmp_load    = 1'b0;
      rd_en       = 1'b0;
      unique case (state_ff)
         salloc_pkg::ST_IDLE, salloc_pkg::ST_INIT: begin
         end
         salloc_pkg::ST_CHECK: begin
            if (is_alloc) begin
               // pop reads the top record, else candidate bump = bump + size
               if (!stack_empty) begin
                  rd_en = 1'b1;
               end else begin
                  tmp_load = 1'b1;
               end
            end else begin
               // offset + size against bump: above top slot or the top slot
               alu_a = AW'(item_ff.slot_offset);
               if (alu_flags.gt) begin
                  commit = out_free;
               end else if (alu_flags.eq) begin
                  commit   = out_free;
                  res_ok   = 1'b1;
                  bump_upd = 1'b1;
                  bump_new = RW'(item_ff.slot_offset);
               end
            end
         end
         salloc_pkg::ST_STACK: begin
            // new end plus one record must not pass the stack bottom
            alu_b  = AW'(salloc_pkg::RECORD_BYTES);
            alu_c  = AW'(sb_ff);
            commit = out_free;
            res_ok = !alu_flags.gt;
            if (is_alloc) begin
               alu_a       = tmp_ff;
               res_granted = alu_flags.gt ? '0 : salloc_pkg::OFFSET_W'(bump_ff);
               bump_upd    = !alu_flags.gt;
               bump_new    = RW'(tmp_ff);
            end else begin
               alu_a = AW'(bump_ff);
               push  = !alu_flags.gt;
            end
         end
         salloc_pkg::ST_POP: begin
            commit      = out_free;
            res_ok      = 1'b1;
            res_granted = rd_data;
            pop         = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // sequencer state and request capture
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= salloc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= req_payload;
      end
      if (tmp_load) begin
         tmp_ff <= alu_sum;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= salloc_pkg::CSR_DATA_W'(salloc_pkg::RST_SLOT_COUNT);
         slot_bytes_ff <= salloc_pkg::CSR_DATA_W'(salloc_pkg::RST_SLOT_BYTES);
      end else if (csr_we) begin
         unique case (csr_index)
            salloc_pkg::CSR_SLOT_COUNT: slot_count_ff <= csr_wdata;
            salloc_pkg::CSR_SLOT_BYTES: slot_bytes_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // region size, clamped to the physical region
   always_comb begin
      prod      = PW'(slot_count_ff) * PW'(slot_bytes_ff == '0 ? 
                  salloc_pkg::CSR_DATA_W'(1) : slot_bytes_ff);
      region_in = (prod > PW'(REGION_BYTES)) ? RW'(REGION_BYTES) : RW'(prod);
   end

   // pointers and record count
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= salloc_pkg::CSR_DATA_W'(salloc_pkg::RST_SLOT_BYTES);
         bump_ff   <= '0;
         sb_ff     <= RW'(RST_REGION);
         count_ff  <= '0;
      end else if (state_ff == salloc_pkg::ST_INIT) begin
         size_ff   <= (slot_bytes_ff == '0) ? salloc_pkg::CSR_DATA_W'(1) : slot_bytes_ff;
         bump_ff   <= '0;
         sb_ff     <= region_in;
         count_ff  <= '0;
      end else if (commit) begin
         if (bump_upd) begin
            bump_ff <= bump_new;
         end
         if (push) begin
            sb_ff    <= sb_ff - RW'(salloc_pkg::RECORD_BYTES);
            count_ff <= count_ff + 1'b1;
         end else if (pop) begin
            sb_ff    <= sb_ff + RW'(salloc_pkg::RECORD_BYTES);
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_payload_ff.ok             <= res_ok;
         rsp_payload_ff.granted_offset <= res_granted;
         rsp_payload_ff.free_records   <= salloc_pkg::RECORDS_W'(
            push ? count_ff + 1'b1 : (pop ? count_ff - 1'b1 : count_ff));
         rsp_payload_ff.bump_top       <= salloc_pkg::BUMP_W'(bump_upd ? bump_new : bump_ff);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

[test/slot_allocator_with_free_stack_top_test.sv]
// testbench for the slot allocator with free stack: predictor, scoreboard and drivers
`timescale 1ns / 100ps

module slot_allocator_with_free_stack_top_test;

   import salloc_pkg::*;

   localparam int CLOCK_PERIOD   = 10;
   localparam int REGION_SIZE    = 4096;
   localparam int RECORD_SIZE    = RECORD_BYTES;
   localparam int STACK_RECORDS  = REGION_SIZE / RECORD_SIZE;
   localparam int RANDOM_ITEMS   = 1650;
   localparam int SETTLE_CYCLES  = 8;
   localparam int TIMEOUT_NS     = 5_000_000;

   // allocator state mirror and response bookkeeping
   class slot_ledger;
      int count_reg;
      int bytes_reg;
      int bump_ptr;
      int stack_floor;
      int last_granted;
      int mismatch_count;
      logic [OFFSET_W-1:0] record_mem [STACK_RECORDS];
      rsp_payload_type owed_q [$];

      function new();
         count_reg = RST_SLOT_COUNT;
         bytes_reg = RST_SLOT_BYTES;
         last_granted = 0;
         mismatch_count = 0;
         reinit();
      endfunction

      function int slot_size();
         return (bytes_reg != 0) ? bytes_reg : 1;
      endfunction

      // count times size, clamped to the region
      function int region_bytes();
         int prod;
         if (count_reg == 0) return 0;
         prod = count_reg * slot_size();
         if (prod > REGION_SIZE) prod = REGION_SIZE;
         return prod;
      endfunction

      function void reinit();
         bump_ptr = 0;
         stack_floor = region_bytes();
      endfunction

      function int outstanding();
         return owed_q.size();
      endfunction

      // any register write re-initializes both pointers
      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_SLOT_COUNT: count_reg = data;
            CSR_SLOT_BYTES: bytes_reg = data;
         endcase
         reinit();
      endfunction

      // work out the response of an accepted request transaction
      function void note_request(req_payload_type req);
         int region;
         int size;
         int addr;
         int top;
         int cand;
         int idx;
         int records;
         logic ok;
         logic [OFFSET_W-1:0] granted;
         rsp_payload_type want;
         region = region_bytes();
         size = slot_size();
         addr = req.slot_offset;
         ok = 1'b0;
         granted = '0;
         if (req.cmd == CMD_ALLOC) begin
            // pop a record first, else bump unless it meets the next record
            if (stack_floor < region) begin
               idx = (region - stack_floor) / RECORD_SIZE - 1;
               if (idx >= 0 && idx < STACK_RECORDS) granted = record_mem[idx];
               stack_floor += RECORD_SIZE;
               ok = 1'b1;
            end else if (bump_ptr + size <= stack_floor - RECORD_SIZE) begin
               granted = bump_ptr[OFFSET_W-1:0];
               bump_ptr += size;
               ok = 1'b1;
            end
            if (ok) last_granted = granted;
         end else begin
            top = bump_ptr - size;
            if (addr == top) begin
               // top slot only lowers the bump pointer
               bump_ptr = top;
               ok = 1'b1;
            end else if (addr < top) begin
               cand = stack_floor - RECORD_SIZE;
               if (cand >= bump_ptr) begin
                  idx = (region - cand) / RECORD_SIZE - 1;
                  if (idx >= 0 && idx < STACK_RECORDS) record_mem[idx] = req.slot_offset;
                  stack_floor = cand;
                  ok = 1'b1;
               end
            end
         end
         records = (region - stack_floor) / RECORD_SIZE;
         want.ok = ok;
         want.granted_offset = granted;
         want.free_records = records[RECORDS_W-1:0];
         want.bump_top = bump_ptr[BUMP_W-1:0];
         owed_q.push_back(want);
      endfunction

      task report(string what);
         $display("%0t mismatch: %s", $realtime, what);
         mismatch_count++;
      endtask

      // compare an accepted response transaction with the oldest prediction
      task check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (owed_q.size() == 0) begin
            report($sformatf("response with nothing outstanding: %p", got));
            return;
         end
         want = owed_q.pop_front();
         if (got.ok !== want.ok)
            report($sformatf("ok got %0d want %0d", got.ok, want.ok));
         if (got.granted_offset !== want.granted_offset)
            report($sformatf("granted_offset got %0d want %0d",
                             got.granted_offset, want.granted_offset));
         if (got.free_records !== want.free_records)
            report($sformatf("free_records got %0d want %0d",
                             got.free_records, want.free_records));
         if (got.bump_top !== want.bump_top)
            report($sformatf("bump_top got %0d want %0d", got.bump_top, want.bump_top));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_SLOT_COUNT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   slot_ledger ledger = new();

   int stall_mode = 0;
   int stall_left = 0;

   slot_allocator_with_free_stack_top #(
      .REGION_BYTES(REGION_SIZE)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // response side: check accepted transactions, stall on changing patterns
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) ledger.check_response(rsp_payload);
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) == 1);
         2: rsp_ready <= (stall_left % 4 == 0);
         default: rsp_ready <= ($urandom_range(0, 24) == 0);
      endcase
   end

   // hold one request transaction until it is accepted
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [OFFSET_W-1:0] offset);
      req_payload_type item;
      item.cmd = cmd;
      item.slot_offset = offset;
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      ledger.note_request(item);
   endtask

   task automatic pause_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (ledger.outstanding() != 0) @(posedge clock);
   endtask

   // write both registers once the block has gone idle
   task automatic reconfigure(input int count_val, input int bytes_val);
      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_SLOT_COUNT;
      csr_wdata <= count_val[CSR_DATA_W-1:0];
      @(posedge clock);
      ledger.write_register(CSR_SLOT_COUNT, count_val[CSR_DATA_W-1:0]);
      csr_index <= CSR_SLOT_BYTES;
      csr_wdata <= bytes_val[CSR_DATA_W-1:0];
      @(posedge clock);
      ledger.write_register(CSR_SLOT_BYTES, bytes_val[CSR_DATA_W-1:0]);
      csr_we <= 1'b0;
   endtask

   // free offsets: mostly plausible slots, some above the top or arbitrary
   function automatic logic [OFFSET_W-1:0] pick_free_offset();
      int size;
      int top;
      int pick;
      size = ledger.slot_size();
      top = ledger.bump_ptr - size;
      pick = $urandom_range(0, 4095);
      case ($urandom_range(0, 9))
         0, 1, 2: if (top >= 0) pick = top;
         3, 4: if (top >= 0) pick = size * $urandom_range(0, top / size);
         5: if (top >= 0) pick = $urandom_range(0, top);
         6: pick = ledger.last_granted;
         7: if (top < 4095) pick = $urandom_range((top < 0) ? 0 : top + 1, 4095);
         default: ;
      endcase
      return pick[OFFSET_W-1:0];
   endfunction

   initial begin
      int phase;
      int i;
      int n;
      int done;
      int alloc_pct;
      int burst_left;
      int gap;
      int count_val;
      int bytes_val;

      reset <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: empty bump area, above top, unaligned, repeated, stale records
      send_request(CMD_FREE, 12'd0);
      send_request(CMD_ALLOC, 12'hFFF);
      send_request(CMD_FREE, 12'hFFF);
      send_request(CMD_ALLOC, 12'd0);
      send_request(CMD_ALLOC, 12'd0);
      send_request(CMD_ALLOC, 12'd0);
      send_request(CMD_FREE, 12'd5);
      send_request(CMD_FREE, 12'd5);
      send_request(CMD_FREE, 12'd16);
      send_request(CMD_FREE, 12'd48);
      send_request(CMD_FREE, 12'd32);
      send_request(CMD_FREE, 12'd16);
      send_request(CMD_ALLOC, 12'd0);
      send_request(CMD_ALLOC, 12'd0);
      send_request(CMD_ALLOC, 12'd0);
      send_request(CMD_ALLOC, 12'd0);
      send_request(CMD_FREE, 12'hAAA);
      send_request(CMD_FREE, 12'h555);

      // zero count, zero size, oversized region, tiny region filling up
      reconfigure(0, 16);
      send_request(CMD_ALLOC, 12'd0);
      send_request(CMD_FREE, 12'd0);
      reconfigure(1, 0);
      send_request(CMD_ALLOC, 12'd0);
      reconfigure(8191, 8191);
      send_request(CMD_ALLOC, 12'd0);
      reconfigure(3, 4);
      send_request(CMD_ALLOC, 12'd0);
      send_request(CMD_ALLOC, 12'd0);
      send_request(CMD_ALLOC, 12'd0);
      send_request(CMD_FREE, 12'd0);
      send_request(CMD_ALLOC, 12'd0);

      // random phases, each under its own settings
      done = 0;
      phase = 0;
      burst_left = 0;
      alloc_pct = 75;
      while (done < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: begin
               count_val = $urandom_range(0, 8191);
               bytes_val = $urandom_range(0, 8191);
            end
            1, 2: begin
               case ($urandom_range(0, 5))
                  0: begin count_val = 1; bytes_val = 1; end
                  1: begin count_val = 4096; bytes_val = 1; end
                  2: begin count_val = 1; bytes_val = 4096; end
                  3: begin count_val = 0; bytes_val = 0; end
                  4: begin count_val = 8191; bytes_val = 8191; end
                  default: begin count_val = 2; bytes_val = 2; end
               endcase
            end
            default: begin
               count_val = $urandom_range(1, 48);
               bytes_val = $urandom_range(1, 24);
            end
         endcase
         reconfigure(count_val, bytes_val);
         n = $urandom_range(40, 160);
         for (i = 0; i < n; i++) begin
            // alternate fill and drain biased stretches
            if (i % 30 == 0) alloc_pct = ((i / 30) % 2 == 0) ? 75 : 35;
            if (i == n / 2 && (phase == 0 || $urandom_range(0, 3) == 0)) drain_responses();
            if (burst_left == 0) begin
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               if (gap > 0) pause_sender(gap);
               burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            if ($urandom_range(0, 99) < alloc_pct)
               send_request(CMD_ALLOC, OFFSET_W'($urandom_range(0, 4095)));
            else
               send_request(CMD_FREE, pick_free_offset());
            done++;
         end
         phase++;
      end

      drain_responses();
      repeat (10) @(posedge clock);
      if (ledger.mismatch_count == 0 && ledger.outstanding() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // hard stop if the handshakes hang
   initial begin
      #(TIMEOUT_NS);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[filelist.f]
rtl/salloc_pkg.sv
rtl/salloc_alu.sv
rtl/salloc_stack_mem.sv
rtl/slot_allocator_with_free_stack_top.sv
test/slot_allocator_with_free_stack_top_test.sv
